FILE: rtl/mrrs_pkg.sv
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared types and constants of the multilevel round-robin scheduler.
// ----------------------------------------------------------------------------
package mrrs_pkg;

    localparam int TASK_COUNT      = 64;
    localparam int LEVEL_COUNT     = 8;
    localparam int TASKS_PER_LEVEL = 16;

    localparam int TID_W   = 6;
    localparam int LVL_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int SLICE_W = 32;

    localparam int LIST_DEPTH = LEVEL_COUNT * TASKS_PER_LEVEL;
    localparam int LIST_AW    = LVL_W + SLOT_W;
    localparam int CLR_W      = $clog2(LIST_DEPTH + 1);

    localparam int SCAN_W      = 8;
    localparam int SCAN_GROUPS = TASK_COUNT / SCAN_W;
    localparam int GRP_W       = 3;
    localparam int OFF_W       = 3;

    localparam logic [SLICE_W-1:0] DEFAULT_SLICE = 32'd2;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_ALLOC = 2'd1,
        K_RUN   = 2'd2,
        K_SLEEP = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_FULL   = 2'd2,
        ST_IGN    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TS_FREE  = 2'd0,
        TS_ALLOC = 2'd1,
        TS_RUN   = 2'd2,
        TS_RSVD  = 2'd3
    } tstate_t;

    typedef struct packed {
        tstate_t              state;
        logic [LVL_W-1:0]     level;
        logic [SLICE_W-1:0]   slice;
    } tent_t;

    typedef struct packed {
        kind_t                kind;
        logic [TID_W-1:0]     task_id;
        logic [3:0]           level;
        logic [SLICE_W-1:0]   priority_req;
    } req_t;

    typedef struct packed {
        logic [TID_W-1:0]     current_task;
        logic [SLICE_W-1:0]   time_slice;
        logic                 reload_timer;
        logic                 switched;
        logic [TID_W-1:0]     new_task;
        status_t              status;
    } res_t;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [TID_W-1:0]     id;
    } alloc_rsp_t;

endpackage

FILE: rtl/multilevel_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler_core
// Multilevel round-robin scheduler: one result per request.
// ----------------------------------------------------------------------------
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | kind, task_id, level, priority_req
//   out     | out_valid / out_stall   | current_task, time_slice, reload_timer,
//           |                         | switched, new_task, status
//
// One request at a time. An allocate searches the free bitmap, eight tasks
// a cycle; a sleep, or a run that moves a task to another level, removes it
// by walking the level list, reading and comparing each entry on the list
// memory port. After reset a clearing pass fills the memories; in_stall is
// high meanwhile. A result held by out_stall does not block the next request.
module multilevel_round_robin_scheduler_core
    import mrrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [TID_W-1:0]    task_id,
    input  logic signed [3:0]   level,
    input  logic [SLICE_W-1:0]  priority_req,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TID_W-1:0]    current_task,
    output logic [SLICE_W-1:0]  time_slice,
    output logic                reload_timer,
    output logic                switched,
    output logic [TID_W-1:0]    new_task,
    output logic [1:0]          status
);

    logic       eng_idle;
    logic       eng_done;
    logic       accept;
    logic       out_ready;
    logic       alloc_go;
    req_t       req;
    res_t       eng_res;
    res_t       res_reg;
    logic       out_valid_reg;
    alloc_rsp_t alloc_rsp;

    assign accept    = in_valid && eng_idle;
    assign in_stall  = !eng_idle;
    assign out_ready = !out_valid_reg || !out_stall;

    assign req.kind         = kind_t'(kind);
    assign req.task_id      = task_id;
    assign req.level        = level;
    assign req.priority_req = priority_req;

    mrrs_alloc u_alloc (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (alloc_go),
        .rsp   (alloc_rsp)
    );

    mrrs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .req       (req),
        .out_ready (out_ready),
        .idle      (eng_idle),
        .done      (eng_done),
        .res       (eng_res),
        .alloc_go  (alloc_go),
        .alloc_rsp (alloc_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            res_reg <= eng_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_task = res_reg.current_task;
    assign time_slice   = res_reg.time_slice;
    assign reload_timer = res_reg.reload_timer;
    assign switched     = res_reg.switched;
    assign new_task     = res_reg.new_task;
    assign status       = res_reg.status;

endmodule

FILE: rtl/mrrs_alloc.sv
// ----------------------------------------------------------------------------
// mrrs_alloc
// Free-task bitmap with a lowest-free search, eight tasks per cycle.
// ----------------------------------------------------------------------------
module mrrs_alloc
    import mrrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    output alloc_rsp_t rsp
);

    logic [TASK_COUNT-1:0] free_reg;
    logic                  busy_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [SCAN_W-1:0]     grp_bits;
    logic                  hit;
    logic [OFF_W-1:0]      off;
    logic                  last_grp;

    assign grp_bits = free_reg[grp_reg * SCAN_W +: SCAN_W];
    assign hit      = |grp_bits;
    assign last_grp = (grp_reg == GRP_W'(SCAN_GROUPS - 1));

    always_comb
    begin
        off = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (grp_bits[i])
            begin
                off = OFF_W'(i);
            end
        end
    end

    assign rsp.done  = busy_reg && (hit || last_grp);
    assign rsp.found = busy_reg && hit;
    assign rsp.id    = {grp_reg, off};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= {{(TASK_COUNT - 2){1'b1}}, 2'b00};
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            grp_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                free_reg[{grp_reg, off}] <= 1'b0;
                busy_reg <= 1'b0;
            end
            else if (last_grp)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                grp_reg <= grp_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mrrs_engine.sv
// ----------------------------------------------------------------------------
// mrrs_engine
// Event sequencer around the task table and the level list memories.
// ----------------------------------------------------------------------------
module mrrs_engine
    import mrrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  req_t       req,
    input  logic       out_ready,
    output logic       idle,
    output logic       done,
    output res_t       res,
    output logic       alloc_go,
    input  alloc_rsp_t alloc_rsp
);

    typedef enum logic [19:0] {
        S_INIT    = 20'h00001,
        S_IDLE    = 20'h00002,
        S_TK_RD   = 20'h00004,
        S_TK_UPD  = 20'h00008,
        S_AL_WAIT = 20'h00010,
        S_AL_WR   = 20'h00020,
        S_T_RD    = 20'h00040,
        S_T_EV    = 20'h00080,
        S_RUN_CHK = 20'h00100,
        S_SL_CHK  = 20'h00200,
        S_RM_INIT = 20'h00400,
        S_RM_RD   = 20'h00800,
        S_RM_CMP  = 20'h01000,
        S_RM_END  = 20'h02000,
        S_RUN_ADD = 20'h04000,
        S_SL_END  = 20'h08000,
        S_FN_RD   = 20'h10000,
        S_FN_TRD  = 20'h20000,
        S_FN_SL   = 20'h40000,
        S_OUT     = 20'h80000
    } state_t;

    state_t               state_reg, state_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    req_t                 req_reg, req_next;
    res_t                 res_reg, res_next;
    logic [TID_W-1:0]     cur0_reg, cur0_next;
    tstate_t              tst_reg, tst_next;
    logic [LVL_W-1:0]     tlev_reg, tlev_next;
    logic [SLICE_W-1:0]   tslice_reg, tslice_next;
    logic [LVL_W-1:0]     tl_reg, tl_next;
    logic [TID_W-1:0]     alid_reg, alid_next;
    logic                 wascur_reg, wascur_next;
    logic [LVL_W-1:0]     rm_lv_reg, rm_lv_next;
    logic [CNT_W-1:0]     rm_n_reg, rm_n_next;
    logic [CNT_W-1:0]     rm_k_reg, rm_k_next;
    logic                 rm_found_reg, rm_found_next;
    logic [CNT_W-1:0]     rm_pos_reg, rm_pos_next;

    logic [CNT_W-1:0]     count_reg  [LEVEL_COUNT];
    logic [CNT_W-1:0]     count_next [LEVEL_COUNT];
    logic [SLOT_W-1:0]    cursor_reg  [LEVEL_COUNT];
    logic [SLOT_W-1:0]    cursor_next [LEVEL_COUNT];
    logic [LVL_W-1:0]     active_reg, active_next;
    logic                 dirty_reg, dirty_next;

    // task table and level lists
    tent_t                t_mem [TASK_COUNT];
    tent_t                t_rdata, t_wdata;
    logic                 t_we;
    logic [TID_W-1:0]     t_waddr, t_raddr;
    logic [TID_W-1:0]     l_mem [LIST_DEPTH];
    logic [TID_W-1:0]     l_rdata, l_wdata;
    logic                 l_we;
    logic [LIST_AW-1:0]   l_waddr, l_raddr;

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            t_mem[t_waddr] <= t_wdata;
        end
        t_rdata <= t_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[l_waddr] <= l_wdata;
        end
        l_rdata <= l_mem[l_raddr];
    end

    logic [LVL_W-1:0]     lsel;
    logic [CNT_W-1:0]     cnt_sel;
    logic [SLOT_W-1:0]    cur_sel;
    logic [LVL_W-1:0]     pick_lv;
    logic [3:0]           tl4;
    logic                 must_add;
    logic [CNT_W-1:0]     rm_nn, rm_c1, rm_c2, rm_km1, cur_ext;

    always_comb
    begin
        unique case (state_reg)
            S_RUN_CHK, S_RUN_ADD: lsel = tl_reg;
            S_RM_INIT, S_RM_END:  lsel = rm_lv_reg;
            default:              lsel = active_reg;
        endcase
    end

    assign cnt_sel = count_reg[lsel];
    assign cur_sel = cursor_reg[lsel];
    assign cur_ext = {1'b0, cur_sel};

    // lowest non-empty level, last level when all are empty
    always_comb
    begin
        pick_lv = LVL_W'(LEVEL_COUNT - 1);
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                pick_lv = LVL_W'(i);
            end
        end
    end

    assign tl4      = req_reg.level[3] ? {1'b0, t_rdata.level} : req_reg.level;
    assign must_add = !(tst_reg == TS_RUN && tlev_reg == tl_reg);
    assign rm_nn    = rm_n_reg - 1'b1;
    assign rm_km1   = rm_k_reg - 1'b1;
    assign rm_c1    = (rm_pos_reg < cur_ext) ? cur_ext - 1'b1 : cur_ext;
    assign rm_c2    = (rm_c1 >= rm_nn) ? '0 : rm_c1;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        cur0_next     = cur0_reg;
        tst_next      = tst_reg;
        tlev_next     = tlev_reg;
        tslice_next   = tslice_reg;
        tl_next       = tl_reg;
        alid_next     = alid_reg;
        wascur_next   = wascur_reg;
        rm_lv_next    = rm_lv_reg;
        rm_n_next     = rm_n_reg;
        rm_k_next     = rm_k_reg;
        rm_found_next = rm_found_reg;
        rm_pos_next   = rm_pos_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        active_next   = active_reg;
        dirty_next    = dirty_reg;
        t_we          = 1'b0;
        t_waddr       = '0;
        t_wdata       = '0;
        t_raddr       = '0;
        l_we          = 1'b0;
        l_waddr       = '0;
        l_wdata       = '0;
        l_raddr       = '0;
        alloc_go      = 1'b0;
        done          = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                l_we    = 1'b1;
                l_waddr = clr_reg[LIST_AW-1:0];
                l_wdata = (clr_reg == CLR_W'(TASKS_PER_LEVEL * (LEVEL_COUNT - 1))) ?
                          TID_W'(1) : '0;
                t_we    = (clr_reg < CLR_W'(TASK_COUNT));
                t_waddr = clr_reg[TID_W-1:0];
                if (clr_reg == '0)
                begin
                    t_wdata = '{TS_RUN, '0, SLICE_W'(2)};
                end
                else if (clr_reg == CLR_W'(1))
                begin
                    t_wdata = '{TS_RUN, LVL_W'(LEVEL_COUNT - 1), SLICE_W'(1)};
                end
                else
                begin
                    t_wdata = '{TS_FREE, '0, DEFAULT_SLICE};
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(LIST_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    res_next = '0;
                    unique case (req.kind)
                        K_TICK:
                        begin
                            res_next.reload_timer = 1'b1;
                            state_next = S_TK_RD;
                        end
                        K_ALLOC:
                        begin
                            alloc_go   = 1'b1;
                            state_next = S_AL_WAIT;
                        end
                        default:
                        begin
                            state_next = S_T_RD;
                        end
                    endcase
                end
            end

            S_TK_RD:
            begin
                l_raddr    = {active_reg, cur_sel};
                state_next = S_TK_UPD;
            end

            S_TK_UPD:
            begin
                cur0_next = l_rdata;
                if (cur_ext + 1'b1 >= cnt_sel)
                begin
                    cursor_next[active_reg] = '0;
                end
                else
                begin
                    cursor_next[active_reg] = cur_sel + 1'b1;
                end
                if (dirty_reg)
                begin
                    active_next = pick_lv;
                    dirty_next  = 1'b0;
                end
                state_next = S_FN_RD;
            end

            S_AL_WAIT:
            begin
                t_raddr = alloc_rsp.id;
                if (alloc_rsp.done)
                begin
                    if (alloc_rsp.found)
                    begin
                        alid_next         = alloc_rsp.id;
                        res_next.new_task = alloc_rsp.id;
                        state_next        = S_AL_WR;
                    end
                    else
                    begin
                        res_next.status = ST_NOFREE;
                        state_next      = S_FN_RD;
                    end
                end
            end

            S_AL_WR:
            begin
                // keep the stored level, reset the slice
                t_we       = 1'b1;
                t_waddr    = alid_reg;
                t_wdata    = '{TS_ALLOC, t_rdata.level, DEFAULT_SLICE};
                state_next = S_FN_RD;
            end

            S_T_RD:
            begin
                t_raddr    = req_reg.task_id;
                state_next = S_T_EV;
            end

            S_T_EV:
            begin
                tst_next    = t_rdata.state;
                tlev_next   = t_rdata.level;
                tslice_next = t_rdata.slice;
                l_raddr     = {active_reg, cur_sel};
                if (req_reg.kind == K_RUN)
                begin
                    if (t_rdata.state == TS_FREE || tl4 >= 4'(LEVEL_COUNT))
                    begin
                        res_next.status = ST_IGN;
                        state_next      = S_FN_RD;
                    end
                    else
                    begin
                        tl_next    = tl4[LVL_W-1:0];
                        state_next = S_RUN_CHK;
                    end
                end
                else if (t_rdata.state != TS_RUN)
                begin
                    res_next.status = ST_IGN;
                    state_next      = S_FN_RD;
                end
                else
                begin
                    state_next = S_SL_CHK;
                end
            end

            S_RUN_CHK:
            begin
                if (must_add && cnt_sel >= CNT_W'(TASKS_PER_LEVEL))
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_FN_RD;
                end
                else
                begin
                    if (req_reg.priority_req != '0)
                    begin
                        tslice_next = req_reg.priority_req;
                    end
                    if (tst_reg == TS_RUN && tlev_reg != tl_reg)
                    begin
                        rm_lv_next = tlev_reg;
                        state_next = S_RM_INIT;
                    end
                    else
                    begin
                        state_next = S_RUN_ADD;
                    end
                end
            end

            S_SL_CHK:
            begin
                wascur_next = (cnt_sel != '0) && (l_rdata == req_reg.task_id);
                rm_lv_next  = tlev_reg;
                state_next  = S_RM_INIT;
            end

            S_RM_INIT:
            begin
                rm_n_next     = cnt_sel;
                rm_k_next     = '0;
                rm_found_next = 1'b0;
                state_next    = S_RM_RD;
            end

            S_RM_RD:
            begin
                if (rm_k_reg < rm_n_reg)
                begin
                    l_raddr    = {rm_lv_reg, rm_k_reg[SLOT_W-1:0]};
                    state_next = S_RM_CMP;
                end
                else
                begin
                    state_next = S_RM_END;
                end
            end

            S_RM_CMP:
            begin
                // search until found, then shift each later entry down by one
                if (!rm_found_reg)
                begin
                    if (l_rdata == req_reg.task_id)
                    begin
                        rm_found_next = 1'b1;
                        rm_pos_next   = rm_k_reg;
                    end
                end
                else
                begin
                    l_we    = 1'b1;
                    l_waddr = {rm_lv_reg, rm_km1[SLOT_W-1:0]};
                    l_wdata = l_rdata;
                end
                rm_k_next  = rm_k_reg + 1'b1;
                state_next = S_RM_RD;
            end

            S_RM_END:
            begin
                if (rm_found_reg)
                begin
                    count_next[rm_lv_reg]  = rm_nn;
                    cursor_next[rm_lv_reg] = rm_c2[SLOT_W-1:0];
                    tst_next               = TS_ALLOC;
                    if (rm_nn == '0)
                    begin
                        dirty_next = 1'b1;
                    end
                end
                state_next = (req_reg.kind == K_RUN) ? S_RUN_ADD : S_SL_END;
            end

            S_RUN_ADD:
            begin
                t_we    = 1'b1;
                t_waddr = req_reg.task_id;
                t_wdata = '{tst_reg, tlev_reg, tslice_reg};
                if (tst_reg == TS_ALLOC)
                begin
                    l_we               = 1'b1;
                    l_waddr            = {tl_reg, cnt_sel[SLOT_W-1:0]};
                    l_wdata            = req_reg.task_id;
                    count_next[tl_reg] = cnt_sel + 1'b1;
                    tst_next           = TS_RUN;
                    tlev_next          = tl_reg;
                    t_wdata            = '{TS_RUN, tl_reg, tslice_reg};
                end
                dirty_next = 1'b1;
                state_next = S_FN_RD;
            end

            S_SL_END:
            begin
                t_we    = 1'b1;
                t_waddr = req_reg.task_id;
                t_wdata = '{tst_reg, tlev_reg, tslice_reg};
                if (wascur_reg)
                begin
                    active_next       = pick_lv;
                    dirty_next        = 1'b0;
                    res_next.switched = 1'b1;
                end
                state_next = S_FN_RD;
            end

            S_FN_RD:
            begin
                l_raddr    = {active_reg, cur_sel};
                state_next = S_FN_TRD;
            end

            S_FN_TRD:
            begin
                res_next.current_task = l_rdata;
                t_raddr               = l_rdata;
                if (req_reg.kind == K_TICK)
                begin
                    res_next.switched = (l_rdata != cur0_reg);
                end
                state_next = S_FN_SL;
            end

            S_FN_SL:
            begin
                res_next.time_slice = t_rdata.slice;
                state_next          = S_OUT;
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            clr_reg    <= '0;
            active_reg <= '0;
            dirty_reg  <= 1'b1;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                count_reg[i]  <= (i == 0 || i == LEVEL_COUNT - 1) ? CNT_W'(1) : '0;
                cursor_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            active_reg <= active_next;
            dirty_reg  <= dirty_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        cur0_reg     <= cur0_next;
        tst_reg      <= tst_next;
        tlev_reg     <= tlev_next;
        tslice_reg   <= tslice_next;
        tl_reg       <= tl_next;
        alid_reg     <= alid_next;
        wascur_reg   <= wascur_next;
        rm_lv_reg    <= rm_lv_next;
        rm_n_reg     <= rm_n_next;
        rm_k_reg     <= rm_k_next;
        rm_found_reg <= rm_found_next;
        rm_pos_reg   <= rm_pos_next;
    end

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg[active_reg] == '0) ||
        ({1'b0, cursor_reg[active_reg]} < count_reg[active_reg]))
        else $error("active cursor beyond list end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[active_reg] <= CNT_W'(TASKS_PER_LEVEL))
        else $error("level count over capacity");

    a_alloc_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_rsp.done |-> (state_reg == S_AL_WAIT))
        else $error("allocation result with no waiting request");

    a_tick_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TK_UPD) |=> !dirty_reg)
        else $error("levels still dirty after tick");

endmodule

FILE: tb/mrrs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrrs_checker
// Watches both channels of the scheduler, keeps its own model of the task
// tables and level lists, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module mrrs_checker
    import mrrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [TID_W-1:0]    task_id,
    input  logic signed [3:0]   level,
    input  logic [SLICE_W-1:0]  priority_req,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [TID_W-1:0]    current_task,
    input  logic [SLICE_W-1:0]  time_slice,
    input  logic                reload_timer,
    input  logic                switched,
    input  logic [TID_W-1:0]    new_task,
    input  logic [1:0]          status,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count,
    output int                  tick_count,
    output int                  busy_count
);

    tstate_t             tstate [TASK_COUNT];
    logic [LVL_W-1:0]    tlevel [TASK_COUNT];
    logic [SLICE_W-1:0]  tslice [TASK_COUNT];
    logic [TID_W-1:0]    lists  [LEVEL_COUNT][TASKS_PER_LEVEL];
    int                  lcount [LEVEL_COUNT];
    int                  lcursor[LEVEL_COUNT];
    int                  act_level;
    bit                  dirty;
    res_t                sched_expect[$];

    function automatic logic [TID_W-1:0] cur_of(int lv);
        return lists[lv][lcursor[lv]];
    endfunction

    function automatic void repick();
        int l;
        for (l = 0; l < LEVEL_COUNT; l++)
            if (lcount[l] > 0) break;
        act_level = (l >= LEVEL_COUNT) ? LEVEL_COUNT - 1 : l;
        dirty = 0;
    endfunction

    function automatic void unlink(int t);
        int lv;
        int n;
        int i;
        lv = tlevel[t];
        n = lcount[lv];
        for (i = 0; i < n; i++)
            if (lists[lv][i] == t) break;
        if (i >= n) return;
        n--;
        lcount[lv] = n;
        if (i < lcursor[lv]) lcursor[lv]--;
        if (lcursor[lv] >= n) lcursor[lv] = 0;
        for (; i < n && i + 1 < TASKS_PER_LEVEL; i++)
            lists[lv][i] = lists[lv][i + 1];
        tstate[t] = TS_ALLOC;
        if (n == 0) dirty = 1;
    endfunction

    function automatic res_t schedule(kind_t k, int t, logic [3:0] lraw,
                                      logic [SLICE_W-1:0] prio);
        res_t r;
        int lv;
        int tl;
        logic [TID_W-1:0] cur;
        bit was_cur;
        bit must_add;
        r = '0;
        r.status = ST_OK;
        case (k)
            K_TICK: begin
                lv = act_level;
                cur = cur_of(lv);
                if (lcursor[lv] + 1 >= lcount[lv]) lcursor[lv] = 0;
                else lcursor[lv]++;
                if (dirty) repick();
                r.switched = (cur_of(act_level) != cur);
                r.reload_timer = 1'b1;
            end
            K_ALLOC: begin
                r.status = ST_NOFREE;
                for (int i = 0; i < TASK_COUNT; i++)
                    if (tstate[i] == TS_FREE) begin
                        tstate[i] = TS_ALLOC;
                        tslice[i] = DEFAULT_SLICE;
                        r.new_task = TID_W'(i);
                        r.status = ST_OK;
                        break;
                    end
            end
            K_RUN: begin
                if (tstate[t] == TS_FREE) r.status = ST_IGN;
                else begin
                    tl = lraw[3] ? int'(tlevel[t]) : int'(lraw);
                    if (tl >= LEVEL_COUNT) r.status = ST_IGN;
                    else begin
                        must_add = !(tstate[t] == TS_RUN && tlevel[t] == tl);
                        if (must_add && lcount[tl] >= TASKS_PER_LEVEL)
                            r.status = ST_FULL;
                        else begin
                            if (prio > 0) tslice[t] = prio;
                            if (tstate[t] == TS_RUN && tlevel[t] != tl) unlink(t);
                            if (tstate[t] == TS_ALLOC) begin
                                tlevel[t] = LVL_W'(tl);
                                lists[tl][lcount[tl]] = TID_W'(t);
                                lcount[tl]++;
                                tstate[t] = TS_RUN;
                            end
                            dirty = 1;
                        end
                    end
                end
            end
            default: begin
                if (tstate[t] != TS_RUN) r.status = ST_IGN;
                else begin
                    lv = act_level;
                    was_cur = lcount[lv] > 0 && cur_of(lv) == t;
                    unlink(t);
                    if (was_cur) begin
                        repick();
                        r.switched = 1'b1;
                    end
                end
            end
        endcase
        cur = cur_of(act_level);
        r.current_task = cur;
        r.time_slice = tslice[cur];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                tstate[i] = TS_FREE;
                tlevel[i] = '0;
                tslice[i] = DEFAULT_SLICE;
            end
            foreach (lists[l, k]) lists[l][k] = '0;
            for (int l = 0; l < LEVEL_COUNT; l++)
            begin
                lcount[l] = 0;
                lcursor[l] = 0;
            end
            tstate[0] = TS_RUN;
            tstate[1] = TS_RUN;
            tlevel[1] = LVL_W'(LEVEL_COUNT - 1);
            tslice[1] = SLICE_W'(1);
            lcount[0] = 1;
            lists[LEVEL_COUNT - 1][0] = TID_W'(1);
            lcount[LEVEL_COUNT - 1] = 1;
            act_level = 0;
            dirty = 1;
            sched_expect.delete();
            fail_count = 0;
            pending_count = 0;
            result_count = 0;
            tick_count = 0;
            busy_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (kind == K_TICK) tick_count++;
                sched_expect.push_back(schedule(kind_t'(kind), task_id, level,
                                                priority_req));
            end
            if (in_stall) busy_count++;
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (sched_expect.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result task=%0d", $time, current_task);
                end
                else
                begin
                    e = sched_expect.pop_front();
                    if (e.current_task !== current_task || e.time_slice !== time_slice
                        || e.reload_timer !== reload_timer || e.switched !== switched
                        || e.new_task !== new_task || e.status !== status)
                    begin
                        fail_count++;
                        $display("%0t: expected task=%0d slice=%0d rl=%0b sw=%0b new=%0d st=%0d",
                                 $time, e.current_task, e.time_slice, e.reload_timer,
                                 e.switched, e.new_task, e.status);
                        $display("%0t: actual   task=%0d slice=%0d rl=%0b sw=%0b new=%0d st=%0d",
                                 $time, current_task, time_slice, reload_timer,
                                 switched, new_task, status);
                    end
                end
            end
            pending_count = sched_expect.size();
        end
    end

endmodule

FILE: tb/multilevel_round_robin_scheduler_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler_core_test
// Drives directed and random scheduler requests with random gaps and stalls;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module multilevel_round_robin_scheduler_core_test;
    import mrrs_pkg::*;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_stall;
    logic [1:0]          kind = K_TICK;
    logic [TID_W-1:0]    task_id = 0;
    logic signed [3:0]   level = 0;
    logic [SLICE_W-1:0]  priority_req = 0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [TID_W-1:0]    current_task;
    logic [SLICE_W-1:0]  time_slice;
    logic                reload_timer;
    logic                switched;
    logic [TID_W-1:0]    new_task;
    logic [1:0]          status;
    int                  fail_count;
    int                  pending_count;
    int                  result_count;
    int                  tick_count;
    int                  busy_count;
    int                  idle_cycles = 0;
    bit                  hold_rx = 0;
    bit                  quiet_rx = 0;

    localparam int WATCHDOG = 20000;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    multilevel_round_robin_scheduler_core uut (.*);

    mrrs_checker checker_i (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one request from the next edge on, hold it until accepted.
    task automatic send(kind_t k, int t, int lv, logic [SLICE_W-1:0] p);
        @(posedge clk);
        in_valid <= 1;
        kind <= k;
        task_id <= TID_W'(t);
        level <= 4'(lv);
        priority_req <= p;
        do @(posedge clk); while (in_stall);
        in_valid <= 0;
    endtask

    task automatic send_gap(kind_t k, int t, int lv, logic [SLICE_W-1:0] p);
        send(k, t, lv, p);
        repeat (gap_len()) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Receiver: random stalls, with a long hold when asked.
    always @(posedge clk)
    begin
        int n;
        if (hold_rx)
        begin
            out_stall <= 1;
        end
        else if (quiet_rx)
        begin
            out_stall <= 0;
        end
        else
        begin
            n = gap_len();
            out_stall <= (n > 0);
            repeat (n > 0 ? n - 1 : 0) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d results outstanding", pending_count);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int r;
        int t;
        int lv;
        logic [SLICE_W-1:0] p;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: ticks on reset state, allocs, runs, sleeps, edges.
        quiet_rx = 1;
        send(K_TICK, 0, 0, 0);
        send(K_TICK, 0, 0, 0);
        send(K_ALLOC, 0, 0, 0);
        send(K_RUN, 2, 0, 32'hFFFF_FFFF);
        send(K_RUN, 2, 7, 1);
        send(K_RUN, 2, -1, 0);
        send(K_RUN, 5, 3, 9);
        send(K_RUN, 2, 8, 4);
        send(K_RUN, 0, -8, 0);
        send(K_SLEEP, 0, 0, 0);
        send(K_SLEEP, 0, 0, 0);
        send(K_SLEEP, 63, 0, 0);
        send(K_TICK, 0, 0, 0);
        send(K_SLEEP, 1, 0, 0);
        send(K_SLEEP, 2, 0, 0);
        send(K_TICK, 0, 0, 0);
        send(K_TICK, 0, 0, 0);
        send(K_RUN, 1, 5, 32'h8000_0000);
        send(K_TICK, 63, 7, 32'h5555_5555);
        drain();
        // Fill level 4 to overflow, exhaust free tasks.
        for (int i = 0; i < 63; i++) send(K_ALLOC, 0, 0, 0);
        for (int i = 2; i < 20; i++) send(K_RUN, i, 4, i);
        send(K_TICK, 0, 0, 0);
        quiet_rx = 0;
        drain();

        // Long receiver hold while requests keep coming.
        hold_rx = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 30; i++) send(K_TICK, i, 0, 0);
        join
        drain();

        for (int n = 0; n < 1200; n++)
        begin
            r = $urandom_range(0, 99);
            t = $urandom_range(0, 63);
            lv = $urandom_range(0, 9) == 0 ? $urandom_range(8, 15) : $urandom_range(0, 7);
            if (lv >= 8) lv = lv - 16;
            p = $urandom_range(0, 3) == 0 ? 0 :
                ($urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(1, 20));
            if (r < 35) send_gap(K_TICK, t, lv, p);
            else if (r < 45) send_gap(K_ALLOC, t, lv, p);
            else if (r < 75) send_gap(K_RUN, t, lv, p);
            else send_gap(K_SLEEP, t, lv, p);
            if (n == 600) drain();
        end
        drain();

        $display("Covered %0d results, %0d ticks, %0d cycles with input stalled.",
                 result_count, tick_count, busy_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mrrs_pkg.sv
rtl/mrrs_alloc.sv
rtl/mrrs_engine.sv
rtl/multilevel_round_robin_scheduler_core.sv
tb/mrrs_checker.sv
tb/multilevel_round_robin_scheduler_core_test.sv
